// ----- rtl/qvr_pkg.sv -----
`default_nettype none

package qvr_pkg;

	localparam int FRAC_BITS = 14;

	localparam int COMP_W = 16;
	localparam int QUAT_W = 16;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_QUAT_I    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_J    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_K    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_REAL = CFG_IDX_W'(3);

	localparam logic signed [QUAT_W-1:0] QUAT_REAL_RST = QUAT_W'(1 << FRAC_BITS);

	localparam int PQ_W  = 2 * QUAT_W;
	localparam int M_W   = PQ_W + 1;
	localparam int P_W   = M_W + COMP_W;
	localparam int RND_SHIFT = 2 * FRAC_BITS - 1;
	localparam int SUM_W = (2 * FRAC_BITS + 1 > P_W + 2) ? 2 * FRAC_BITS + 1 : P_W + 2;
	localparam int Q_W   = SUM_W - RND_SHIFT;
	localparam int EXT_W = ((Q_W > COMP_W) ? Q_W : COMP_W) + 1;

	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (RND_SHIFT - 1);
	localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(32767);
	localparam logic signed [EXT_W-1:0] SAT_MIN = -EXT_W'(32768);

	typedef struct packed {
		logic signed [COMP_W-1:0] vec_x;
		logic signed [COMP_W-1:0] vec_y;
		logic signed [COMP_W-1:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] rot_x;
		logic signed [COMP_W-1:0] rot_y;
		logic signed [COMP_W-1:0] rot_z;
		logic                     saturated;
	} rot_t;

endpackage

`default_nettype wire

// ----- rtl/quaternion_vector_rotate.sv -----
`default_nettype none

// Rotates each input word (vec_x, vec_y, vec_z) by the 3x3 matrix formed from the
// quaternion in registers quat_i, quat_j, quat_k, quat_real (Q1.14, index 0..3; reset
// gives identity). The matrix is the transposed form, i.e. rotation by the conjugate;
// the quaternion is not normalized. Outputs are rounded half up and saturated to signed
// 16 bits, with saturated set if any component clipped. One word is taken every cycle
// unless the output stalls; stages are quaternion product, matrix sum, matrix-vector
// multiply, accumulate/round and saturate. Write registers only while the block holds
// no word; a word taken the cycle after a write already sees the new value.
module quaternion_vector_rotate (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  qvr_pkg::vec_t               in_data,
	output logic                              out_valid,
	input  wire                               out_ready,
	output qvr_pkg::rot_t                     out_data,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [qvr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [qvr_pkg::QUAT_W-1:0]        cfg_data
);

	localparam int QW   = qvr_pkg::QUAT_W;
	localparam int CW   = qvr_pkg::COMP_W;
	localparam int PQW  = qvr_pkg::PQ_W;
	localparam int MW   = qvr_pkg::M_W;
	localparam int PW   = qvr_pkg::P_W;
	localparam int SW   = qvr_pkg::SUM_W;
	localparam int QSW  = qvr_pkg::Q_W;
	localparam int EW   = qvr_pkg::EXT_W;

	logic signed [QW-1:0] quat_i_q, quat_j_q, quat_k_q, quat_real_q;

	logic en1, en2, en3, en4, en5;
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;

	qvr_pkg::vec_t vec_s1, vec_s2, vec_s3, vec_s4;
	logic signed [PQW-1:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [MW-1:0]  m_s2 [9];
	logic signed [PW-1:0]  p_s3 [9];
	logic signed [QSW-1:0] q_s4 [3];
	qvr_pkg::rot_t         out_data_q;

	logic signed [CW-1:0]  comp_s2 [3];
	logic signed [CW-1:0]  comp_s4 [3];
	logic signed [SW-1:0]  sum_c [3];
	logic signed [EW-1:0]  res_c [3];
	logic signed [CW-1:0]  clip_c [3];
	logic [2:0]            sat_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_i_q    <= '0;
			quat_j_q    <= '0;
			quat_k_q    <= '0;
			quat_real_q <= qvr_pkg::QUAT_REAL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				qvr_pkg::REG_QUAT_I:    quat_i_q    <= cfg_data;
				qvr_pkg::REG_QUAT_J:    quat_j_q    <= cfg_data;
				qvr_pkg::REG_QUAT_K:    quat_k_q    <= cfg_data;
				qvr_pkg::REG_QUAT_REAL: quat_real_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the next one advances
	assign en5      = !out_valid_q || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) out_valid_q <= v_s4;
		end
	end

	assign comp_s2[0] = vec_s2.vec_x;
	assign comp_s2[1] = vec_s2.vec_y;
	assign comp_s2[2] = vec_s2.vec_z;
	assign comp_s4[0] = vec_s4.vec_x;
	assign comp_s4[1] = vec_s4.vec_y;
	assign comp_s4[2] = vec_s4.vec_z;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = SW'(p_s3[3*r]) + SW'(p_s3[3*r+1]) + SW'(p_s3[3*r+2])
				+ qvr_pkg::RND_HALF;
			res_c[r] = EW'(comp_s4[r]) + EW'(q_s4[r]);
			if (res_c[r] > qvr_pkg::SAT_MAX) begin
				clip_c[r] = CW'(qvr_pkg::SAT_MAX);
				sat_c[r]  = 1'b1;
			end else if (res_c[r] < qvr_pkg::SAT_MIN) begin
				clip_c[r] = CW'(qvr_pkg::SAT_MIN);
				sat_c[r]  = 1'b1;
			end else begin
				clip_c[r] = CW'(res_c[r]);
				sat_c[r]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			vec_s1 <= in_data;
			xx_s1  <= quat_i_q * quat_i_q;
			yy_s1  <= quat_j_q * quat_j_q;
			zz_s1  <= quat_k_q * quat_k_q;
			xy_s1  <= quat_i_q * quat_j_q;
			xz_s1  <= quat_i_q * quat_k_q;
			yz_s1  <= quat_j_q * quat_k_q;
			wx_s1  <= quat_real_q * quat_i_q;
			wy_s1  <= quat_real_q * quat_j_q;
			wz_s1  <= quat_real_q * quat_k_q;
		end
		if (en2 && v_s1) begin
			vec_s2  <= vec_s1;
			m_s2[0] <= -(MW'(yy_s1) + MW'(zz_s1));
			m_s2[1] <= MW'(xy_s1) + MW'(wz_s1);
			m_s2[2] <= MW'(xz_s1) - MW'(wy_s1);
			m_s2[3] <= MW'(xy_s1) - MW'(wz_s1);
			m_s2[4] <= -(MW'(xx_s1) + MW'(zz_s1));
			m_s2[5] <= MW'(yz_s1) + MW'(wx_s1);
			m_s2[6] <= MW'(xz_s1) + MW'(wy_s1);
			m_s2[7] <= MW'(yz_s1) - MW'(wx_s1);
			m_s2[8] <= -(MW'(xx_s1) + MW'(yy_s1));
		end
		if (en3 && v_s2) begin
			vec_s3 <= vec_s2;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					p_s3[3*r+c] <= m_s2[3*r+c] * comp_s2[c];
				end
			end
		end
		if (en4 && v_s3) begin
			vec_s4 <= vec_s3;
			for (int r = 0; r < 3; r++) begin
				q_s4[r] <= QSW'(sum_c[r] >>> qvr_pkg::RND_SHIFT);
			end
		end
		if (en5 && v_s4) begin
			out_data_q.rot_x     <= clip_c[0];
			out_data_q.rot_y     <= clip_c[1];
			out_data_q.rot_z     <= clip_c[2];
			out_data_q.saturated <= |sat_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted word missing from first stage");

	a_empty_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with empty first stage");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en4 |=> v_s4 && $stable(vec_s4))
		else $error("stalled word lost in accumulate stage");

	a_s4_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && en5 |=> out_valid)
		else $error("accumulate stage word did not reach output");

	a_cfg_real: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == qvr_pkg::REG_QUAT_REAL
		|=> quat_real_q == $past(cfg_data))
		else $error("real part register not written");

endmodule

`default_nettype wire

// ----- tb/sv/quaternion_vector_rotate_checker.sv -----
`default_nettype none

module quaternion_vector_rotate_checker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               in_ready,
	input  wire  qvr_pkg::vec_t               in_data,
	input  wire                               out_valid,
	input  wire                               out_ready,
	input  wire  qvr_pkg::rot_t               out_data,
	input  wire                               cfg_valid,
	input  wire                               cfg_ready,
	input  wire  [qvr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [qvr_pkg::QUAT_W-1:0]        cfg_data,
	output int                                mismatches,
	output int                                pending
);

	localparam int REPORT_MAX = 10;
	localparam int QW = qvr_pkg::QUAT_W;
	localparam int CW = qvr_pkg::COMP_W;
	localparam int PROD_SHIFT = 2 * qvr_pkg::FRAC_BITS;

	logic signed [QW-1:0] q_i;
	logic signed [QW-1:0] q_j;
	logic signed [QW-1:0] q_k;
	logic signed [QW-1:0] q_w;

	qvr_pkg::rot_t rotated_q[$];

	function automatic logic signed [CW-1:0] round_clip(input longint v, input longint s,
			inout bit clip);
		longint r;
		r = v + ((s + (longint'(1) <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT);
		if (r > 32767) begin
			r = 32767;
			clip = 1'b1;
		end else if (r < -32768) begin
			r = -32768;
			clip = 1'b1;
		end
		return r[CW-1:0];
	endfunction

	function automatic qvr_pkg::rot_t rotate_vec(input qvr_pkg::vec_t v);
		longint x, y, z, w, vx, vy, vz;
		longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
		longint sx, sy, sz;
		bit clip;
		qvr_pkg::rot_t r;
		x = q_i;
		y = q_j;
		z = q_k;
		w = q_w;
		vx = v.vec_x;
		vy = v.vec_y;
		vz = v.vec_z;
		xx = 2 * x * x;
		yy = 2 * y * y;
		zz = 2 * z * z;
		xy = 2 * x * y;
		xz = 2 * x * z;
		yz = 2 * y * z;
		wx = 2 * w * x;
		wy = 2 * w * y;
		wz = 2 * w * z;
		sx = -(yy + zz) * vx + (xy + wz) * vy + (xz - wy) * vz;
		sy = (xy - wz) * vx - (xx + zz) * vy + (yz + wx) * vz;
		sz = (xz + wy) * vx + (yz - wx) * vy - (xx + yy) * vz;
		clip = 1'b0;
		r.rot_x = round_clip(vx, sx, clip);
		r.rot_y = round_clip(vy, sy, clip);
		r.rot_z = round_clip(vz, sz, clip);
		r.saturated = clip;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		qvr_pkg::rot_t want;
		if (!arst_n) begin
			q_i = '0;
			q_j = '0;
			q_k = '0;
			q_w = qvr_pkg::QUAT_REAL_RST;
			rotated_q.delete();
			mismatches = 0;
		end else begin
			if (in_valid && in_ready)
				rotated_q.push_back(rotate_vec(in_data));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					qvr_pkg::REG_QUAT_I:    q_i = cfg_data;
					qvr_pkg::REG_QUAT_J:    q_j = cfg_data;
					qvr_pkg::REG_QUAT_K:    q_k = cfg_data;
					qvr_pkg::REG_QUAT_REAL: q_w = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("unexpected word: x=%0d y=%0d z=%0d sat=%0b",
							out_data.rot_x, out_data.rot_y, out_data.rot_z,
							out_data.saturated);
					mismatches++;
				end else begin
					want = rotated_q.pop_front();
					if (out_data.rot_x !== want.rot_x || out_data.rot_y !== want.rot_y ||
							out_data.rot_z !== want.rot_z ||
							out_data.saturated !== want.saturated) begin
						if (mismatches < REPORT_MAX)
							$display({"rotate mismatch: expected x=%0d y=%0d z=%0d ",
								"sat=%0b, got x=%0d y=%0d z=%0d sat=%0b"},
								want.rot_x, want.rot_y, want.rot_z, want.saturated,
								out_data.rot_x, out_data.rot_y, out_data.rot_z,
								out_data.saturated);
						mismatches++;
					end
				end
			end
		end
		pending = rotated_q.size();
	end

endmodule

`default_nettype wire

// ----- tb/sv/quaternion_vector_rotate_tb.sv -----
`default_nettype none

module quaternion_vector_rotate_tb;

	localparam int ITEMS = 1800;
	localparam int PHASES = 12;
	localparam int LIMIT_CYCLES = 400000;
	localparam int IW = qvr_pkg::CFG_IDX_W;
	localparam int QW = qvr_pkg::QUAT_W;
	localparam int CW = qvr_pkg::COMP_W;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	qvr_pkg::vec_t        in_data = '0;
	logic                 out_ready = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [IW-1:0]        cfg_index = '0;
	logic [QW-1:0]        cfg_data = '0;
	wire                  in_ready;
	wire                  out_valid;
	wire                  cfg_ready;
	qvr_pkg::rot_t        out_data;

	bit steady = 1'b0;
	bit in_took = 1'b0;
	bit cfg_took = 1'b0;
	int mismatches;
	int pending;

	always #1 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_took <= 1'b0;
			cfg_took <= 1'b0;
		end else begin
			in_took <= in_valid && in_ready;
			cfg_took <= cfg_valid && cfg_ready;
		end
	end

	always @(negedge clk) begin
		out_ready <= steady || $urandom_range(99) >= 35;
	end

	quaternion_vector_rotate u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	quaternion_vector_rotate_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	task automatic send_vec(input qvr_pkg::vec_t v);
		while (!steady && $urandom_range(99) < 35) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = v;
		do @(negedge clk); while (!in_took);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [QW-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(negedge clk); while (!cfg_took);
		cfg_valid = 1'b0;
	endtask

	task automatic write_quat(input logic [QW-1:0] qi, input logic [QW-1:0] qj,
			input logic [QW-1:0] qk, input logic [QW-1:0] qw);
		write_reg(qvr_pkg::REG_QUAT_I, qi);
		write_reg(qvr_pkg::REG_QUAT_J, qj);
		write_reg(qvr_pkg::REG_QUAT_K, qk);
		write_reg(qvr_pkg::REG_QUAT_REAL, qw);
	endtask

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		qvr_pkg::vec_t corners[8];
		qvr_pkg::vec_t v;
		real a, b, c, d, norm;
		int sel;

		corners = '{
			'{16'sh0000, 16'sh0000, 16'sh0000},
			'{16'sh7fff, 16'sh7fff, 16'sh7fff},
			'{16'sh8000, 16'sh8000, 16'sh8000},
			'{16'sh7fff, 16'sh8000, 16'sh0000},
			'{16'sh0001, 16'shffff, 16'sh0001},
			'{16'shffff, 16'sh0000, 16'sh7fff},
			'{16'sh5555, 16'shaaaa, 16'sh5555},
			'{16'shaaaa, 16'sh5555, 16'shaaaa}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// identity from reset
		foreach (corners[n])
			send_vec(corners[n]);
		wait_drained();

		// oversized quaternion: drive components into saturation
		write_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		foreach (corners[n])
			send_vec(corners[n]);
		wait_drained();

		// unmapped indexes must leave the quaternion alone
		for (int n = qvr_pkg::REG_QUAT_REAL + 1; n < 2 ** IW; n++)
			write_reg(IW'(n), QW'($urandom));
		for (int n = 1; n < 5; n++)
			send_vec(corners[n]);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			steady = (p == 4 || p == 5);
			if (p == 0) begin
				write_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
			end else if (p == 1) begin
				write_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
			end else if (p == 2) begin
				write_quat(16'h8000, 16'h7fff, 16'h0000, 16'h8000);
			end else if (p == 3) begin
				write_quat(16'h0000, 16'h0000, 16'sd11585, 16'sd11585);
			end else if (p % 3 == 0) begin
				write_quat(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
			end else begin
				a = real'($urandom_range(65534)) - 32767.0;
				b = real'($urandom_range(65534)) - 32767.0;
				c = real'($urandom_range(65534)) - 32767.0;
				d = real'($urandom_range(65534)) - 32767.0;
				norm = $sqrt(a * a + b * b + c * c + d * d);
				if (norm == 0.0)
					norm = 1.0;
				write_quat(QW'(int'(a / norm * 16384.0)),
					QW'(int'(b / norm * 16384.0)),
					QW'(int'(c / norm * 16384.0)),
					QW'(int'(d / norm * 16384.0)));
			end
			for (int n = 0; n < ITEMS / PHASES; n++) begin
				sel = $urandom_range(99);
				if (sel < 70) begin
					v.vec_x = CW'($urandom);
					v.vec_y = CW'($urandom);
					v.vec_z = CW'($urandom);
				end else if (sel < 85) begin
					v.vec_x = CW'(int'($urandom_range(200)) - 100);
					v.vec_y = CW'(int'($urandom_range(200)) - 100);
					v.vec_z = CW'(int'($urandom_range(200)) - 100);
				end else begin
					v = corners[3'($urandom_range(7))];
				end
				send_vec(v);
			end
			wait_drained();
		end

		if (mismatches == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// ----- quaternion_vector_rotate.f -----
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate.sv
tb/sv/quaternion_vector_rotate_checker.sv
tb/sv/quaternion_vector_rotate_tb.sv
